/* rtl/contiguous_fit_allocator_macros.svh */
// Assertion macros shared by the checker.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
// Implication on the same edge, disabled during reset.
`define CFA_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Implication on the next edge, disabled during reset.
`define CFA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

/* rtl/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg
// Payload types and codes of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;
  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_FIND    = 2'd2;
  localparam logic [1:0] FIT_FIRST   = 2'd0;
  localparam logic [1:0] FIT_BEST    = 2'd1;
  localparam logic [1:0] FIT_NEXT    = 2'd2;
  localparam logic       STAT_OK     = 1'b0;
  localparam logic       STAT_FAIL   = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  owner_id;
    logic [10:0] size;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  start_res;
    logic [10:0] length;
  } out_item_t;
endpackage

/* rtl/cfa_ram.sv */
// ----------------------------------------------------------------------------
// cfa_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cfa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/contiguous_fit_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Owner map allocator with first, best and next fit placement.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid/in_ready   | cfa_pkg::in_item_t
//  out_    | output    | out_valid/out_ready | cfa_pkg::out_item_t
//  cfg_    | input     | APB, pready high    | fit_mode at address 0
//
// After reset a clearing pass writes every unit free while in_ready stays
// low. A request scans the map one unit per cycle through the single RAM
// port, with each word examined in the cycle after its read, and then writes
// its run, one unit per cycle. First fit stops at the first run that fits,
// best fit always scans the whole map. Next fit that finds nothing from the
// saved position scans a second time from zero. Release and find scan until
// the end of the owner's first run; release then writes the run back free.
// Rejected requests and reserved actions go straight to the output state
// without a scan. A finished result sits in the output register; the next
// transfer is taken once it has left.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int MEMORY_UNITS  = 1024,
  parameter int OWNER_ID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cfa_pkg::out_item_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  localparam int AW = $clog2(MEMORY_UNITS);
  localparam int CW = AW + 1;
  localparam int MW = OWNER_ID_BITS + 1;
  localparam logic [CW-1:0] UNITS = CW'(MEMORY_UNITS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [AW-1:0] np_r, np_nxt;
  cfa_pkg::in_item_t item_r, item_nxt;
  // Read address counter and the address of the word now on rdata.
  logic [CW-1:0] raddr_r, raddr_nxt;
  logic          rv_r, rv_nxt;
  logic [CW-1:0] daddr_r, daddr_nxt;
  // Current free run, or the owner's run for release and find.
  logic          inrun_r, inrun_nxt;
  logic [CW-1:0] rstart_r, rstart_nxt;
  logic [CW-1:0] rlen_r, rlen_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] hstart_r, hstart_nxt;
  logic [CW-1:0] hlen_r, hlen_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [CW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] wend_r, wend_nxt;
  logic          out_valid_r, out_valid_nxt;
  cfa_pkg::out_item_t out_r, out_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [MW-1:0] wdata, rdata;

  cfa_ram #(.WIDTH(MW), .DEPTH(MEMORY_UNITS)) u_map (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic                     used;
  logic [OWNER_ID_BITS-1:0] oid;
  logic [OWNER_ID_BITS-1:0] req_id;
  logic [CW-1:0]            need;
  logic                     is_req;
  logic [CW-1:0]            np_ext;

  assign used   = rdata[MW-1];
  assign oid    = rdata[OWNER_ID_BITS-1:0];
  assign req_id = OWNER_ID_BITS'(item_r.owner_id);
  assign need   = CW'(item_r.size);
  assign is_req = (item_r.action == cfa_pkg::ACT_REQUEST);
  assign np_ext = CW'(np_r);

  assign in_ready   = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, mode_r};

  always_comb begin
    logic          fin;
    logic [CW-1:0] flen;
    logic          cand;
    logic          good;
    fin = 1'b0; flen = '0; cand = 1'b0; good = 1'b0;
    state_nxt = state_r; mode_nxt = mode_r; np_nxt = np_r; item_nxt = item_r;
    raddr_nxt = raddr_r; rv_nxt = 1'b0; daddr_nxt = raddr_r;
    inrun_nxt = inrun_r; rstart_nxt = rstart_r; rlen_nxt = rlen_r;
    hit_nxt = hit_r; hstart_nxt = hstart_r; hlen_nxt = hlen_r;
    wrapped_nxt = wrapped_r; wptr_nxt = wptr_r; wend_nxt = wend_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    we = 1'b0; addr = raddr_r[AW-1:0]; wdata = '0;

    if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) begin
      mode_nxt = cfg_pwdata[1:0];
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        raddr_nxt = raddr_r + 1'b1;
        if (raddr_r == UNITS - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          inrun_nxt = 1'b0; hit_nxt = 1'b0; rlen_nxt = '0; rstart_nxt = '0;
          hstart_nxt = '0; hlen_nxt = '0;
          wrapped_nxt = 1'b0;
          if (in_data.action == cfa_pkg::ACT_REQUEST &&
              (in_data.size == '0 || 32'(in_data.size) > 32'(MEMORY_UNITS))) begin
            state_nxt = S_OUT;
          end else if (in_data.action == cfa_pkg::ACT_REQUEST ||
                       in_data.action == cfa_pkg::ACT_RELEASE ||
                       in_data.action == cfa_pkg::ACT_FIND) begin
            raddr_nxt = (in_data.action == cfa_pkg::ACT_REQUEST &&
                         mode_r == cfa_pkg::FIT_NEXT) ? np_ext : '0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // Issue reads in order; each word is examined in the next cycle.
        if (raddr_r < UNITS) begin
          rv_nxt = 1'b1;
          raddr_nxt = raddr_r + 1'b1;
        end
        if (rv_r) begin
          if (is_req) begin
            if (!used) begin
              if (!inrun_r) begin
                rstart_nxt = daddr_r; rlen_nxt = CW'(1);
              end else begin
                rlen_nxt = rlen_r + 1'b1;
              end
              inrun_nxt = 1'b1;
            end else begin
              inrun_nxt = 1'b0;
            end
            // A run closes at a held unit or at the last unit.
            if (inrun_r && used) begin
              cand = 1'b1; flen = rlen_r;
            end else if (!used && daddr_r == UNITS - 1'b1) begin
              cand = 1'b1; flen = inrun_r ? rlen_r + 1'b1 : CW'(1);
            end
            good = cand && (flen >= need);
            if (good) begin
              if (mode_r == cfa_pkg::FIT_BEST) begin
                if (!hit_r || flen < hlen_r) begin
                  hit_nxt = 1'b1; hlen_nxt = flen;
                  hstart_nxt = (inrun_r) ? rstart_r : daddr_r;
                end
              end else if (!(mode_r == cfa_pkg::FIT_NEXT && wrapped_r &&
                             ((inrun_r ? rstart_r : daddr_r) >= np_ext))) begin
                hit_nxt = 1'b1; hlen_nxt = flen;
                hstart_nxt = inrun_r ? rstart_r : daddr_r;
                fin = 1'b1;
              end
            end
            if (!fin && daddr_r == UNITS - 1'b1) begin
              if (mode_r == cfa_pkg::FIT_NEXT && !wrapped_r && np_r != '0) begin
                // Second pass from zero; runs must start below np.
                wrapped_nxt = 1'b1; inrun_nxt = 1'b0;
                raddr_nxt = '0; rv_nxt = 1'b0;
              end else begin
                fin = 1'b1;
              end
            end
          end else begin
            if (used && oid == req_id) begin
              if (!hit_r) begin
                hit_nxt = 1'b1; hstart_nxt = daddr_r; hlen_nxt = CW'(1);
              end else begin
                hlen_nxt = hlen_r + 1'b1;
              end
              if (daddr_r == UNITS - 1'b1) begin
                fin = 1'b1;
              end
            end else if (hit_r || daddr_r == UNITS - 1'b1) begin
              fin = 1'b1;
            end
          end
          if (fin) begin
            rv_nxt = 1'b0;
            if (hit_nxt && (is_req || item_r.action == cfa_pkg::ACT_RELEASE)) begin
              wptr_nxt = hstart_nxt;
              wend_nxt = hstart_nxt + (is_req ? need : hlen_nxt);
              state_nxt = S_WRITE;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_WRITE: begin
        we = 1'b1;
        addr = wptr_r[AW-1:0];
        wdata = is_req ? {1'b1, req_id} : '0;
        wptr_nxt = wptr_r + 1'b1;
        if (wptr_r + 1'b1 >= wend_r) begin
          state_nxt = S_OUT;
          if (is_req) begin
            np_nxt = (wend_r >= UNITS) ? '0 : wend_r[AW-1:0];
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = hit_r ? cfa_pkg::STAT_OK : cfa_pkg::STAT_FAIL;
          out_nxt.start_res = hit_r ? 10'(hstart_r) : '0;
          out_nxt.length = hit_r ? (is_req ? item_r.size : 11'(hlen_r)) : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; mode_r <= cfa_pkg::FIT_FIRST; np_r <= '0;
      raddr_r <= '0; rv_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; mode_r <= mode_nxt; np_r <= np_nxt;
      raddr_r <= raddr_nxt; rv_r <= rv_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; daddr_r <= daddr_nxt; inrun_r <= inrun_nxt;
    rstart_r <= rstart_nxt; rlen_r <= rlen_nxt; hit_r <= hit_nxt;
    hstart_r <= hstart_nxt; hlen_r <= hlen_nxt; wrapped_r <= wrapped_nxt;
    wptr_r <= wptr_nxt; wend_r <= wend_nxt; out_r <= out_nxt;
  end
endmodule

/* rtl/cfa_checker.sv */
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the contiguous fit allocator.
// ----------------------------------------------------------------------------
`include "contiguous_fit_allocator_macros.svh"
module cfa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cfa_pkg::out_item_t out_data,
  input logic               cfg_pready
);
  `CFA_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_data.status, out_data.start_res == '0 && out_data.length == '0, "failed result carries nonzero fields")
  `CFA_ASSERT_NOW(a_ok_len, clk, rst_n, out_valid && !out_data.status, out_data.length != '0, "successful result with zero length")
  `CFA_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer taken while busy")
  `CFA_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while result waits")
  `CFA_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, cfg_pready, "pready dropped")
endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
  .cfg_pready(cfg_pready)
);
